### rtl/lsw_pkg.sv
// shared types, codes and constants for the lap stopwatch
// used by every module of the block but the split store, and by its checker
package lsw_pkg;

    localparam int LAP_STORE_DEPTH_DEF = 256;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 216;

    localparam logic [15:0] LAP_NUM_MAX = 16'hFFFF;

    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_START  = 3'd1;
    localparam logic [2:0] REQ_STOP   = 3'd2;
    localparam logic [2:0] REQ_TOGGLE = 3'd3;
    localparam logic [2:0] REQ_RESET  = 3'd4;
    localparam logic [2:0] REQ_LAP    = 3'd5;

    localparam logic [1:0] RUN_EMPTY   = 2'd0;
    localparam logic [1:0] RUN_PAUSED  = 2'd1;
    localparam logic [1:0] RUN_RUNNING = 2'd2;

    typedef enum logic [1:0] {
        RCL_NONE,
        RCL_CUR,
        RCL_FIRST,
        RCL_MID
    } recall_kind_t;

    typedef struct packed {
        logic         running;
        logic [31:0]  elapsed;
        logic [31:0]  lap_start;
        logic [15:0]  lap_num;
        logic [31:0]  last_len;
        recall_kind_t kind;
    } sw_state_t;

endpackage

### rtl/lsw_split_store.sv
// ring of lap start splits: one write port, two registered read ports
// a read at the address written in the same cycle returns the new split
// depends on lsw_pkg for nothing but is sized by the top level parameter
module lsw_split_store #(
    parameter int LAP_STORE_DEPTH = 256,
    localparam int IDX_W = $clog2(LAP_STORE_DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [31:0]      wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr_lo,
    input  logic [IDX_W-1:0] rd_addr_hi,
    output logic [31:0]      rd_data_lo,
    output logic [31:0]      rd_data_hi
);

    logic [31:0] mem [LAP_STORE_DEPTH];
    logic [31:0] rd_lo_reg;
    logic [31:0] rd_hi_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_lo_reg <= (wr_en && wr_addr == rd_addr_lo) ? wr_data : mem[rd_addr_lo];
            rd_hi_reg <= (wr_en && wr_addr == rd_addr_hi) ? wr_data : mem[rd_addr_hi];
        end
    end

    assign rd_data_lo = rd_lo_reg;
    assign rd_data_hi = rd_hi_reg;

endmodule

### rtl/lsw_tracker.sv
// input register, stopwatch state update and split store addressing
// depends on lsw_pkg for request codes and the state struct
module lsw_tracker #(
    parameter int LAP_STORE_DEPTH = 256,
    localparam int IDX_W = $clog2(LAP_STORE_DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          req_type,
    input  logic [15:0]         recall_lap,
    input  logic                out_ready,
    output logic                st_valid,
    output lsw_pkg::sw_state_t  st,
    output logic                wr_en,
    output logic [IDX_W-1:0]    wr_addr,
    output logic [31:0]         wr_data,
    output logic                rd_en,
    output logic [IDX_W-1:0]    rd_addr_lo,
    output logic [IDX_W-1:0]    rd_addr_hi
);

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(LAP_STORE_DEPTH - 1);
    localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W+1)'(LAP_STORE_DEPTH);

    logic                  in_valid_reg;
    logic [2:0]            req_reg;
    logic [15:0]           recall_reg;
    logic                  st_valid_reg;
    logic                  running_reg, running_next;
    logic [31:0]           elapsed_reg, elapsed_next;
    logic [31:0]           lap_start_reg, lap_start_next;
    logic [15:0]           lap_num_reg, lap_num_next;
    logic [31:0]           last_len_reg, last_len_next;
    logic [IDX_W-1:0]      cur_slot_reg, cur_slot_next;
    lsw_pkg::recall_kind_t kind_reg, kind_next;

    logic             adv_in, adv_st, st_ready;
    logic             lap_wr;
    logic [31:0]      lap_len;
    logic [15:0]      lap_gap;
    logic [IDX_W:0]   hi_sum, hi_wrap;
    logic [IDX_W-1:0] hi_slot;

    assign adv_st   = st_valid_reg && out_ready;
    assign st_ready = !st_valid_reg || adv_st;
    assign adv_in   = in_valid_reg && st_ready;
    assign in_ready = !in_valid_reg || adv_in;

    assign lap_len = elapsed_reg - lap_start_reg;

    always_comb begin
        running_next   = running_reg;
        elapsed_next   = elapsed_reg;
        lap_start_next = lap_start_reg;
        lap_num_next   = lap_num_reg;
        last_len_next  = last_len_reg;
        cur_slot_next  = cur_slot_reg;
        lap_wr         = 1'b0;
        case (req_reg)
            lsw_pkg::REQ_TICK: begin
                if (running_reg) begin
                    elapsed_next = elapsed_reg + 32'd1;
                end
            end
            lsw_pkg::REQ_START: begin
                running_next = 1'b1;
            end
            lsw_pkg::REQ_STOP: begin
                running_next = 1'b0;
            end
            lsw_pkg::REQ_TOGGLE: begin
                running_next = !running_reg;
            end
            lsw_pkg::REQ_RESET: begin
                elapsed_next   = '0;
                lap_start_next = '0;
                lap_num_next   = 16'd1;
                last_len_next  = '0;
                cur_slot_next  = LAST_SLOT;
            end
            lsw_pkg::REQ_LAP: begin
                if (lap_len != '0) begin
                    last_len_next  = lap_len;
                    lap_start_next = elapsed_reg;
                    lap_wr         = 1'b1;
                    if (lap_num_reg != lsw_pkg::LAP_NUM_MAX) begin
                        lap_num_next  = lap_num_reg + 16'd1;
                        cur_slot_next = (cur_slot_reg == LAST_SLOT) ? '0
                                                                    : cur_slot_reg + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // laps behind the current one, less one: the ring distance of lap n+1
    assign lap_gap = lap_num_next - recall_reg - 16'd1;

    always_comb begin
        if (recall_reg == '0 || recall_reg > lap_num_next) begin
            kind_next = lsw_pkg::RCL_NONE;
        end else if (recall_reg == lap_num_next) begin
            kind_next = lsw_pkg::RCL_CUR;
        end else if (recall_reg == 16'd1) begin
            kind_next = ({1'b0, lap_gap} < 17'(LAP_STORE_DEPTH)) ? lsw_pkg::RCL_FIRST
                                                                 : lsw_pkg::RCL_NONE;
        end else begin
            kind_next = ({1'b0, lap_gap} < 17'(LAP_STORE_DEPTH - 1)) ? lsw_pkg::RCL_MID
                                                                     : lsw_pkg::RCL_NONE;
        end
    end

    assign hi_sum  = {1'b0, cur_slot_next} + DEPTH_X - {1'b0, lap_gap[IDX_W-1:0]};
    assign hi_wrap = (hi_sum >= DEPTH_X) ? hi_sum - DEPTH_X : hi_sum;
    assign hi_slot = (kind_next == lsw_pkg::RCL_FIRST || kind_next == lsw_pkg::RCL_MID)
                   ? hi_wrap[IDX_W-1:0] : '0;

    assign rd_en      = adv_in;
    assign rd_addr_hi = hi_slot;
    assign rd_addr_lo = (hi_slot == '0) ? LAST_SLOT : hi_slot - 1'b1;
    assign wr_en      = adv_in && lap_wr;
    assign wr_addr    = cur_slot_next;
    assign wr_data    = elapsed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            st_valid_reg  <= 1'b0;
            running_reg   <= 1'b0;
            elapsed_reg   <= '0;
            lap_start_reg <= '0;
            lap_num_reg   <= 16'd1;
            last_len_reg  <= '0;
            cur_slot_reg  <= LAST_SLOT;
        end else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (st_ready) begin
                st_valid_reg <= adv_in;
            end
            if (adv_in) begin
                running_reg   <= running_next;
                elapsed_reg   <= elapsed_next;
                lap_start_reg <= lap_start_next;
                lap_num_reg   <= lap_num_next;
                last_len_reg  <= last_len_next;
                cur_slot_reg  <= cur_slot_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            req_reg    <= req_type;
            recall_reg <= recall_lap;
        end
        if (adv_in) begin
            kind_reg <= kind_next;
        end
    end

    assign st_valid     = st_valid_reg;
    assign st.running   = running_reg;
    assign st.elapsed   = elapsed_reg;
    assign st.lap_start = lap_start_reg;
    assign st.lap_num   = lap_num_reg;
    assign st.last_len  = last_len_reg;
    assign st.kind      = kind_reg;

endmodule

### rtl/lsw_result.sv
// result register: run state, lap times and the recalled lap
// depends on lsw_pkg for the state struct and run state codes
module lsw_result (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               st_valid,
    output logic               st_ready,
    input  lsw_pkg::sw_state_t st,
    input  logic [31:0]        rd_data_lo,
    input  logic [31:0]        rd_data_hi,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         run_state,
    output logic [31:0]        total_ms,
    output logic [15:0]        lap_count,
    output logic [31:0]        lap_ms,
    output logic [31:0]        prev_lap_ms,
    output logic [31:0]        lap_split_ms,
    output logic [31:0]        recalled_lap_ms,
    output logic [31:0]        recalled_split_ms
);

    logic        m_valid_reg;
    logic [1:0]  run_state_reg;
    logic [31:0] total_reg, lap_ms_reg, prev_reg, split_reg, rec_len_reg, rec_split_reg;
    logic [15:0] lap_count_reg;

    logic        adv;
    logic [1:0]  run_state_next;
    logic [31:0] lap_ms_next, rec_len_next, rec_split_next;

    assign st_ready = !m_valid_reg || m_ready;
    assign adv      = st_valid && st_ready;

    assign lap_ms_next = st.elapsed - st.lap_start;

    always_comb begin
        if (st.running) begin
            run_state_next = lsw_pkg::RUN_RUNNING;
        end else if (st.elapsed == '0) begin
            run_state_next = lsw_pkg::RUN_EMPTY;
        end else begin
            run_state_next = lsw_pkg::RUN_PAUSED;
        end
    end

    always_comb begin
        case (st.kind)
            lsw_pkg::RCL_CUR: begin
                rec_len_next   = lap_ms_next;
                rec_split_next = st.lap_start;
            end
            lsw_pkg::RCL_FIRST: begin
                rec_len_next   = rd_data_hi;
                rec_split_next = '0;
            end
            lsw_pkg::RCL_MID: begin
                rec_len_next   = rd_data_hi - rd_data_lo;
                rec_split_next = rd_data_lo;
            end
            default: begin
                rec_len_next   = '0;
                rec_split_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st_ready) begin
            m_valid_reg <= st_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            run_state_reg <= run_state_next;
            total_reg     <= st.elapsed;
            lap_count_reg <= st.lap_num;
            lap_ms_reg    <= lap_ms_next;
            prev_reg      <= st.last_len;
            split_reg     <= st.lap_start;
            rec_len_reg   <= rec_len_next;
            rec_split_reg <= rec_split_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign run_state         = run_state_reg;
    assign total_ms          = total_reg;
    assign lap_count         = lap_count_reg;
    assign lap_ms            = lap_ms_reg;
    assign prev_lap_ms       = prev_reg;
    assign lap_split_ms      = split_reg;
    assign recalled_lap_ms   = rec_len_reg;
    assign recalled_split_ms = rec_split_reg;

endmodule

### rtl/lap_stopwatch_with_split_store.sv
// top level of the lap stopwatch with its ring of lap start splits
// depends on lsw_pkg, lsw_tracker, lsw_split_store and lsw_result
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tuser: req_type; s_tdata: recall_lap
// m_       out  m_tvalid/m_tready  m_tdata: run state, times, recalled lap
//
// one item per cycle sustained while m_tready is high; a taken item passes the
// input register, the state update with split store read, and the result register
// the split store has one write and two read ports, one write and two reads a cycle
// aresetn clears state and valids synchronously; the split store needs no clearing pass
// each stage moves when the one after it is empty or moving, so bubbles are filled
module lap_stopwatch_with_split_store #(
    parameter int LAP_STORE_DEPTH = lsw_pkg::LAP_STORE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lsw_pkg::S_TDATA_W-1:0] s_tdata,   // recall_lap[15:0]
    input  logic [lsw_pkg::S_TUSER_W-1:0] s_tuser,   // req_type[2:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // run_state[1:0], total_ms[33:2], lap_count[49:34], lap_ms[81:50],
    // prev_lap_ms[113:82], lap_split_ms[145:114], recalled_lap_ms[177:146],
    // recalled_split_ms[209:178], zero[215:210]
    output logic [lsw_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(LAP_STORE_DEPTH);

    lsw_pkg::sw_state_t st;
    logic               st_valid, st_ready;
    logic               wr_en, rd_en;
    logic [IDX_W-1:0]   wr_addr, rd_addr_lo, rd_addr_hi;
    logic [31:0]        wr_data, rd_data_lo, rd_data_hi;

    logic [1:0]  run_state;
    logic [15:0] lap_count;
    logic [31:0] total_ms, lap_ms, prev_lap_ms, lap_split_ms;
    logic [31:0] recalled_lap_ms, recalled_split_ms;

    lsw_tracker #(
        .LAP_STORE_DEPTH(LAP_STORE_DEPTH)
    ) u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .req_type   (s_tuser),
        .recall_lap (s_tdata),
        .out_ready  (st_ready),
        .st_valid   (st_valid),
        .st         (st),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr_lo (rd_addr_lo),
        .rd_addr_hi (rd_addr_hi)
    );

    lsw_split_store #(
        .LAP_STORE_DEPTH(LAP_STORE_DEPTH)
    ) u_store (
        .aclk       (aclk),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr_lo (rd_addr_lo),
        .rd_addr_hi (rd_addr_hi),
        .rd_data_lo (rd_data_lo),
        .rd_data_hi (rd_data_hi)
    );

    lsw_result u_result (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .st_valid          (st_valid),
        .st_ready          (st_ready),
        .st                (st),
        .rd_data_lo        (rd_data_lo),
        .rd_data_hi        (rd_data_hi),
        .m_valid           (m_tvalid),
        .m_ready           (m_tready),
        .run_state         (run_state),
        .total_ms          (total_ms),
        .lap_count         (lap_count),
        .lap_ms            (lap_ms),
        .prev_lap_ms       (prev_lap_ms),
        .lap_split_ms      (lap_split_ms),
        .recalled_lap_ms   (recalled_lap_ms),
        .recalled_split_ms (recalled_split_ms)
    );

    assign m_tdata = {6'b0, recalled_split_ms, recalled_lap_ms, lap_split_ms, prev_lap_ms,
                      lap_ms, lap_count, total_ms, run_state};

endmodule

### rtl/lsw_checker.sv
// port-level checker for the lap stopwatch, bound to the top level
// depends on lsw_pkg for widths and run state codes
module lsw_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [lsw_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [lsw_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lsw_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [1:0]  run_state;
    logic [31:0] total_ms, lap_ms, lap_split_ms;
    logic [15:0] lap_count;

    assign run_state    = m_tdata[1:0];
    assign total_ms     = m_tdata[33:2];
    assign lap_count    = m_tdata[49:34];
    assign lap_ms       = m_tdata[81:50];
    assign lap_split_ms = m_tdata[145:114];

    // a stalled item holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_run_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (run_state == lsw_pkg::RUN_RUNNING)
                  || (run_state == lsw_pkg::RUN_EMPTY && total_ms == '0)
                  || (run_state == lsw_pkg::RUN_PAUSED && total_ms != '0))
        else $error("run state disagrees with elapsed time");

    a_lap_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> lap_ms == total_ms - lap_split_ms)
        else $error("lap time disagrees with elapsed time and split");

    a_lap_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> lap_count != '0)
        else $error("lap number zero");

    logic unused_inputs;
    assign unused_inputs = s_tvalid ^ s_tready ^ (^s_tdata) ^ (^s_tuser);

endmodule

bind lap_stopwatch_with_split_store lsw_checker u_lsw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
